@@ rtl/rgb_to_yuv420_converter_core_defines.svh @@
// ----------------------------------------------------------------------------
// rgb to yuv 4:2:0 converter assertion macros
// checks sampled on the core clock and disabled while reset is low
// ----------------------------------------------------------------------------
`ifndef RGB_TO_YUV420_CONVERTER_CORE_DEFINES_SVH
`define RGB_TO_YUV420_CONVERTER_CORE_DEFINES_SVH

// condition and consequence in the same cycle
`define RGB2YUV_ASSERT_SAME(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// consequence in the cycle after the condition
`define RGB2YUV_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/rgb2yuv_pkg.sv @@
// ----------------------------------------------------------------------------
// rgb2yuv_pkg
// shared widths, coefficients, register codes and types of the converter
// ----------------------------------------------------------------------------
package rgb2yuv_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int PIX_W          = 8;
    localparam int CFG_DATA_W     = 13;
    localparam int FRAME_W_W      = 12;
    localparam int EFF_W          = 13;
    localparam int ROW_W          = 12;
    localparam int CMP_W          = 14;
    localparam int SUM_W          = 25;
    localparam int ENTRY_W        = 16;
    localparam int MAX_HEIGHT     = 4096;
    localparam int FRAME_W_LIMIT  = 4096;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;

    localparam logic [PIX_W-1:0] CHROMA_BIAS = 8'd32;

    // luma weights
    localparam logic signed [SUM_W-1:0] Y_R  = SUM_W'(9796);
    localparam logic signed [SUM_W-1:0] Y_G  = SUM_W'(19235);
    localparam logic signed [SUM_W-1:0] Y_B  = SUM_W'(3736);
    // cb weights
    localparam logic signed [SUM_W-1:0] CB_R = SUM_W'(-4784);
    localparam logic signed [SUM_W-1:0] CB_G = SUM_W'(-9437);
    localparam logic signed [SUM_W-1:0] CB_B = SUM_W'(14221);
    // cr weights
    localparam logic signed [SUM_W-1:0] CR_R = SUM_W'(20218);
    localparam logic signed [SUM_W-1:0] CR_G = SUM_W'(-16941);
    localparam logic signed [SUM_W-1:0] CR_B = SUM_W'(-3277);

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic first;
        logic last;
        logic frame_end;
    } pix_ctrl_t;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] cr;
    } yuv_terms_t;

    // round up to even, at least two, at most lim
    function automatic logic [EFF_W-1:0] round_clamp(input logic [EFF_W-1:0] v,
                                                     input logic [EFF_W-1:0] lim);
        logic [EFF_W:0] r;
        r    = {1'b0, v} + (EFF_W+1)'(1);
        r[0] = 1'b0;
        if (r < (EFF_W+1)'(2))
        begin
            r = (EFF_W+1)'(2);
        end
        if (r > {1'b0, lim})
        begin
            r = {1'b0, lim};
        end
        return r[EFF_W-1:0];
    endfunction

endpackage

@@ rtl/rgb_to_yuv420_converter_core.sv @@
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_core
// raster rgb pixels in, luma per pixel and 2x2 block chroma out
// ----------------------------------------------------------------------------
// The core takes one pixel request per clock while pixel_ready is high and
// returns one result per pixel from its output register. The path is a
// matrix stage, a line store stage and an output register; the chroma of
// each 2x2 block is summed in a line store of MAX_WIDTH/2 entries with one
// read and one write port, read when the pixel is taken and written back
// two stages later, with the two latest writes forwarded. The store needs
// no clearing pass: the first pixel of every block starts from zero. Width
// and height are to be written only while no pixel is in flight: the user
// is bound, the core does not enforce it. They take effect on the next pixel.
`include "rgb_to_yuv420_converter_core_defines.svh"

module rgb_to_yuv420_converter_core #(
    parameter int MAX_WIDTH = rgb2yuv_pkg::DEF_MAX_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  rgb2yuv_pkg::cfg_reg_t              cfg_index,
    input  logic [rgb2yuv_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                               pixel_valid,
    output logic                               pixel_ready,
    input  logic [rgb2yuv_pkg::PIX_W-1:0]      blue,
    input  logic [rgb2yuv_pkg::PIX_W-1:0]      green,
    input  logic [rgb2yuv_pkg::PIX_W-1:0]      red,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [rgb2yuv_pkg::PIX_W-1:0]      luma,
    output logic                               chroma_valid,
    output logic [rgb2yuv_pkg::PIX_W-1:0]      chroma_blue,
    output logic [rgb2yuv_pkg::PIX_W-1:0]      chroma_red,
    output logic                               frame_end
);

    import rgb2yuv_pkg::*;

    localparam int STORE_DEPTH = MAX_WIDTH / 2;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int EVEN_MAX    = MAX_WIDTH - (MAX_WIDTH % 2);
    localparam int WIDTH_LIM   = (EVEN_MAX > FRAME_W_LIMIT) ? FRAME_W_LIMIT : EVEN_MAX;
    localparam int RESET_EFF_W = (RESET_WIDTH > WIDTH_LIM) ? WIDTH_LIM : RESET_WIDTH;

    // configuration, kept as effective width and height
    logic [EFF_W-1:0]   eff_w_reg;
    logic [EFF_W-1:0]   eff_h_reg;

    // raster position of the next pixel
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;

    logic               accept;
    logic               line_end;
    logic               last_row;
    pix_ctrl_t          ctrl_now;
    logic [ADDR_W-1:0]  idx_now;

    // matrix stage
    logic               s1_v_reg;
    pix_ctrl_t          s1_ctrl_reg;
    logic [ADDR_W-1:0]  s1_idx_reg;
    logic [PIX_W-1:0]   s1_blue_reg;
    logic [PIX_W-1:0]   s1_green_reg;
    logic [PIX_W-1:0]   s1_red_reg;
    yuv_terms_t         s1_terms;

    // line store stage
    logic               s2_v_reg;
    pix_ctrl_t          s2_ctrl_reg;
    logic [ADDR_W-1:0]  s2_idx_reg;
    yuv_terms_t         s2_terms_reg;
    logic [ENTRY_W-1:0] s2_entry_reg;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] entry;
    logic [PIX_W-1:0]   acc_b;
    logic [PIX_W-1:0]   acc_r;
    logic [ENTRY_W-1:0] wdata;

    // last two store writes, newest in slot 0
    logic               fwd_v_reg    [2];
    logic [ADDR_W-1:0]  fwd_addr_reg [2];
    logic [ENTRY_W-1:0] fwd_data_reg [2];

    // output register
    logic               out_v_reg;
    logic [PIX_W-1:0]   luma_reg;
    logic               cv_reg;
    logic [PIX_W-1:0]   cb_reg;
    logic [PIX_W-1:0]   cr_reg;
    logic               fe_reg;

    logic               out_en;
    logic               s2_en;
    logic               s1_en;
    logic               s2_adv;

    assign out_en      = !out_v_reg || result_ready;
    assign s2_en       = !s2_v_reg || out_en;
    assign s1_en       = !s1_v_reg || s2_en;
    assign s2_adv      = s2_v_reg && out_en;
    assign pixel_ready = s1_en;
    assign accept      = pixel_valid && s1_en;

    // position decode
    always_comb
    begin
        line_end           = (CMP_W'(col_reg) + CMP_W'(1)) >= CMP_W'(eff_w_reg);
        last_row           = (CMP_W'(row_reg) + CMP_W'(1)) >= CMP_W'(eff_h_reg);
        ctrl_now.first     = !row_reg[0] && !col_reg[0];
        ctrl_now.last      = row_reg[0] && col_reg[0];
        ctrl_now.frame_end = line_end && last_row;
        idx_now            = ADDR_W'(col_reg >> 1);
        if (line_end)
        begin
            col_next = '0;
            row_next = ctrl_now.frame_end ? '0 : row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_w_reg <= EFF_W'(RESET_EFF_W);
            eff_h_reg <= EFF_W'(RESET_HEIGHT);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    eff_w_reg <= round_clamp({1'b0, cfg_data[FRAME_W_W-1:0]},
                                             EFF_W'(WIDTH_LIM));
                end
                REG_FRAME_HEIGHT:
                begin
                    eff_h_reg <= round_clamp(cfg_data, EFF_W'(MAX_HEIGHT));
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    rgb2yuv_matrix u_matrix (
        .blue  (s1_blue_reg),
        .green (s1_green_reg),
        .red   (s1_red_reg),
        .terms (s1_terms)
    );

    rgb2yuv_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s2_adv),
        .waddr (s2_idx_reg),
        .wdata (wdata),
        .re    (accept),
        .raddr (idx_now),
        .rdata (ram_rdata)
    );

    // the read misses at most the two writes still ahead in the pipe
    always_comb
    begin
        if (s2_ctrl_reg.first)
        begin
            entry = '0;
        end
        else if (fwd_v_reg[0] && (fwd_addr_reg[0] == s2_idx_reg))
        begin
            entry = fwd_data_reg[0];
        end
        else if (fwd_v_reg[1] && (fwd_addr_reg[1] == s2_idx_reg))
        begin
            entry = fwd_data_reg[1];
        end
        else
        begin
            entry = s2_entry_reg;
        end
        acc_b = entry[PIX_W-1:0] + s2_terms_reg.cb;
        acc_r = entry[ENTRY_W-1:PIX_W] + s2_terms_reg.cr;
        wdata = {acc_r, acc_b};
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            out_v_reg    <= 1'b0;
            fwd_v_reg[0] <= 1'b0;
            fwd_v_reg[1] <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_v_reg <= pixel_valid;
            end
            if (s2_en)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (out_en)
            begin
                out_v_reg <= s2_v_reg;
            end
            if (s2_adv)
            begin
                fwd_v_reg[0] <= 1'b1;
                fwd_v_reg[1] <= fwd_v_reg[0];
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctrl_reg  <= ctrl_now;
            s1_idx_reg   <= idx_now;
            s1_blue_reg  <= blue;
            s1_green_reg <= green;
            s1_red_reg   <= red;
        end
        if (s2_en && s1_v_reg)
        begin
            s2_ctrl_reg  <= s1_ctrl_reg;
            s2_idx_reg   <= s1_idx_reg;
            s2_terms_reg <= s1_terms;
            s2_entry_reg <= ram_rdata;
        end
        if (s2_adv)
        begin
            fwd_addr_reg[0] <= s2_idx_reg;
            fwd_data_reg[0] <= wdata;
            fwd_addr_reg[1] <= fwd_addr_reg[0];
            fwd_data_reg[1] <= fwd_data_reg[0];
            luma_reg        <= s2_terms_reg.luma;
            cv_reg          <= s2_ctrl_reg.last;
            cb_reg          <= s2_ctrl_reg.last ? acc_b : '0;
            cr_reg          <= s2_ctrl_reg.last ? acc_r : '0;
            fe_reg          <= s2_ctrl_reg.frame_end;
        end
    end

    assign result_valid = out_v_reg;
    assign luma         = luma_reg;
    assign chroma_valid = cv_reg;
    assign chroma_blue  = cb_reg;
    assign chroma_red   = cr_reg;
    assign frame_end    = fe_reg;

    `RGB2YUV_ASSERT_NEXT(a_frame_wrap, accept && ctrl_now.frame_end, (col_reg == '0) && (row_reg == '0), "position did not wrap after the last pixel of a frame")
    `RGB2YUV_ASSERT_NEXT(a_col_in_line, accept && !cfg_write, CMP_W'(col_reg) < CMP_W'(eff_w_reg), "column beyond the line after a pixel")
    `RGB2YUV_ASSERT_SAME(a_chroma_idle, result_valid && !chroma_valid, (chroma_blue == '0) && (chroma_red == '0), "chroma bytes set without a completed block")

endmodule

@@ rtl/rgb2yuv_ram.sv @@
// ----------------------------------------------------------------------------
// rgb2yuv_ram
// simple dual port ram, one write and one registered read port, read-first
// ----------------------------------------------------------------------------
module rgb2yuv_ram #(
    parameter int WIDTH = rgb2yuv_pkg::ENTRY_W,
    parameter int DEPTH = rgb2yuv_pkg::DEF_MAX_WIDTH / 2,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/rgb2yuv_matrix.sv @@
// ----------------------------------------------------------------------------
// rgb2yuv_matrix
// fixed-point color matrix: luma byte and per-pixel cb and cr terms
// ----------------------------------------------------------------------------
module rgb2yuv_matrix (
    input  logic [rgb2yuv_pkg::PIX_W-1:0] blue,
    input  logic [rgb2yuv_pkg::PIX_W-1:0] green,
    input  logic [rgb2yuv_pkg::PIX_W-1:0] red,
    output rgb2yuv_pkg::yuv_terms_t       terms
);

    import rgb2yuv_pkg::*;

    logic signed [SUM_W-1:0] b_s;
    logic signed [SUM_W-1:0] g_s;
    logic signed [SUM_W-1:0] r_s;
    logic signed [SUM_W-1:0] y_sum;
    logic signed [SUM_W-1:0] cb_sum;
    logic signed [SUM_W-1:0] cr_sum;

    assign b_s = signed'({{(SUM_W-PIX_W){1'b0}}, blue});
    assign g_s = signed'({{(SUM_W-PIX_W){1'b0}}, green});
    assign r_s = signed'({{(SUM_W-PIX_W){1'b0}}, red});

    assign y_sum  = Y_R  * r_s + Y_G  * g_s + Y_B  * b_s;
    assign cb_sum = CB_R * r_s + CB_G * g_s + CB_B * b_s;
    assign cr_sum = CR_R * r_s + CR_G * g_s + CR_B * b_s;

    // luma is bits 22:15 of its sum; cb and cr are the low byte of an arithmetic shift by 17, bits 24:17
    always_comb
    begin
        terms.luma = y_sum[22:15];
        terms.cb   = cb_sum[24:17] + CHROMA_BIAS;
        terms.cr   = cr_sum[24:17] + CHROMA_BIAS;
    end

endmodule
